/* rtl/core/leash_follow_controller_assert.svh */
// Assertion macros shared by the leash-follow controller RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef LEASH_FOLLOW_CONTROLLER_ASSERT_SVH
`define LEASH_FOLLOW_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("leash follow controller assertion failed");

// Next-cycle implication, disabled during reset.
`define LFC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("leash follow controller assertion failed");

`endif

/* rtl/core/lfc_pkg.sv */
// Shared types, widths and codes for the leash-follow controller.
// Used by every module of the block; depends on nothing.
package lfc_pkg;

  localparam int WINDOW_MAX   = 10;
  localparam int SENSOR_COUNT = 4;

  localparam int RANGE_W    = 11;
  localparam int DIST_W     = 14;
  localparam int LIMIT_W    = 15;
  localparam int FORCE_W    = 16;
  localparam int CMD_W      = 16;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int WIN_W      = 4;
  localparam int RING_IDX_W = $clog2(WINDOW_MAX);
  localparam int SENS_SUM_W = DIST_W + $clog2(SENSOR_COUNT);
  localparam int VCNT_W     = $clog2(SENSOR_COUNT + 1);
  localparam int FSUM_W     = DIST_W + $clog2(WINDOW_MAX + 1);
  localparam int DIV_W      = FSUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int DIVISOR_W  = 4;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  localparam logic [DIVISOR_W-1:0] SPEED_DIV  = DIVISOR_W'(10);
  localparam logic [FORCE_W:0]     TURN_DEAD  = (FORCE_W + 1)'(5);
  localparam logic [DIST_W-1:0]    RING_RESET = DIST_W'(1000);

  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEST   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OFF   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FORCE = 2'd2;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_TARGET    = 3'd1;
  localparam logic [2:0] REG_SPEED_LIM = 3'd2;
  localparam logic [2:0] REG_TURN_LIM  = 3'd3;
  localparam logic [2:0] REG_WINDOW    = 3'd4;
  localparam logic [2:0] REG_DEAD_ZONE = 3'd5;
  localparam logic [2:0] REG_FORCE_THR = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DIST_W-1:0]  target;
    logic [LIMIT_W-1:0] speed_limit;
    logic [LIMIT_W-1:0] turn_limit;
    logic [WIN_W-1:0]   window;
    logic [DIST_W-1:0]  dead_zone;
    logic [LIMIT_W-1:0] force_thr;
  } cfg_t;

  typedef struct packed {
    logic wr_en;
    logic sum_start;
  } ring_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SENS,
    S_DIV_AVG,
    S_WSUM,
    S_DIV_WIN,
    S_DIV_SPD,
    S_EVAL,
    S_FINISH
  } state_t;

endpackage

/* rtl/core/lfc_regs.sv */
// APB-style configuration registers of the leash-follow controller.
// Depends on lfc_pkg for the register indexes and the cfg_t struct.
module lfc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfc_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfc_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output lfc_pkg::cfg_t                 cfg
);
  import lfc_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_OFF;
      cfg.target      <= RING_RESET;
      cfg.speed_limit <= LIMIT_W'(100);
      cfg.turn_limit  <= LIMIT_W'(100);
      cfg.window      <= WIN_W'(10);
      cfg.dead_zone   <= DIST_W'(50);
      cfg.force_thr   <= LIMIT_W'(100);
    end else if (wr) begin
      unique case (idx)
        REG_MODE:      cfg.mode        <= pwdata[MODE_W-1:0];
        REG_TARGET:    cfg.target      <= pwdata[DIST_W-1:0];
        REG_SPEED_LIM: cfg.speed_limit <= pwdata[LIMIT_W-1:0];
        REG_TURN_LIM:  cfg.turn_limit  <= pwdata[LIMIT_W-1:0];
        REG_WINDOW:    cfg.window      <= pwdata[WIN_W-1:0];
        REG_DEAD_ZONE: cfg.dead_zone   <= pwdata[DIST_W-1:0];
        REG_FORCE_THR: cfg.force_thr   <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MODE:      prdata = PDATA_W'(cfg.mode);
      REG_TARGET:    prdata = PDATA_W'(cfg.target);
      REG_SPEED_LIM: prdata = PDATA_W'(cfg.speed_limit);
      REG_TURN_LIM:  prdata = PDATA_W'(cfg.turn_limit);
      REG_WINDOW:    prdata = PDATA_W'(cfg.window);
      REG_DEAD_ZONE: prdata = PDATA_W'(cfg.dead_zone);
      REG_FORCE_THR: prdata = PDATA_W'(cfg.force_thr);
      default:       prdata = '0;
    endcase
  end

endmodule

/* rtl/core/lfc_serdiv.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lfc_pkg for the dividend and divisor widths.
module lfc_serdiv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [lfc_pkg::DIV_W-1:0]       dividend,
  input  logic [lfc_pkg::DIVISOR_W-1:0]   divisor,
  output logic                            done,
  output logic [lfc_pkg::DIV_W-1:0]       quotient
);
  import lfc_pkg::*;

  logic [DIV_W-1:0]     acc;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   trial_sub;
  logic                 fits;

  assign trial     = {rem, acc[DIV_W-1]};
  assign fits      = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};
  assign quotient  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DIV_CNT_W'(DIV_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= '0;
    end else if (busy) begin
      acc <= {acc[DIV_W-2:0], fits};
      rem <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

endmodule

/* rtl/core/lfc_ring.sv */
// Distance ring buffer with its write pointer and a serial window adder.
// Depends on lfc_pkg for the ring depth, widths and the ring_ctl_t struct.
module lfc_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lfc_pkg::WIN_W-1:0]     window,
  input  lfc_pkg::ring_ctl_t            ctl,
  input  logic [lfc_pkg::DIST_W-1:0]    wr_data,
  output logic [lfc_pkg::WIN_W-1:0]     eff_win,
  output logic                          sum_done,
  output logic [lfc_pkg::FSUM_W-1:0]    sum
);
  import lfc_pkg::*;

  logic [DIST_W-1:0]     ring [WINDOW_MAX];
  logic [RING_IDX_W-1:0] pos;
  logic [RING_IDX_W-1:0] idx;
  logic                  busy;
  logic                  wrap;
  logic                  last;

  always_comb begin
    if (window == '0) begin
      eff_win = WIN_W'(1);
    end else if (window > WIN_W'(WINDOW_MAX)) begin
      eff_win = WIN_W'(WINDOW_MAX);
    end else begin
      eff_win = window;
    end
  end

  assign wrap = ((RING_IDX_W + 1)'(pos) + 1'b1) >= (RING_IDX_W + 1)'(eff_win);
  assign last = idx == RING_IDX_W'(eff_win - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        ring[i] <= RING_RESET;
      end
      pos <= '0;
    end else if (ctl.wr_en) begin
      ring[pos] <= wr_data;
      pos       <= wrap ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sum_done <= 1'b0;
    end else begin
      sum_done <= 1'b0;
      if (ctl.sum_start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy     <= 1'b0;
        sum_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_start) begin
      idx <= '0;
      sum <= '0;
    end else if (busy) begin
      idx <= idx + 1'b1;
      sum <= sum + FSUM_W'(ring[idx]);
    end
  end

endmodule

/* rtl/core/leash_follow_controller.sv */
// Leash-follow controller: a full update reads the four sensors in turn, runs the serial
// divider two or three times and sums the window entries in the ring adder before out_valid
// rises. Mode off or emergency go straight to the output stage; no valid reading ends the
// update after the sensor scan. One item is in work at a time; the next is accepted in the
// cycle after the result loads, and the result waits while the output register is still full.
// Reset loads the register defaults, fills the ring with 1000 mm and sets the status to off.
`include "leash_follow_controller_assert.svh"

module leash_follow_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfc_pkg::PADDR_W-1:0]         paddr,
  input  logic [lfc_pkg::PDATA_W-1:0]         pwdata,
  output logic [lfc_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lfc_pkg::RANGE_W-1:0]  range_a_cm,
  input  logic signed [lfc_pkg::RANGE_W-1:0]  range_b_cm,
  input  logic signed [lfc_pkg::RANGE_W-1:0]  range_c_cm,
  input  logic signed [lfc_pkg::RANGE_W-1:0]  range_d_cm,
  input  logic signed [lfc_pkg::FORCE_W-1:0]  leash_force,
  input  logic                                emergency,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                motor_write,
  output logic signed [lfc_pkg::CMD_W-1:0]    speed_cmd,
  output logic signed [lfc_pkg::CMD_W-1:0]    turn_cmd,
  output logic [lfc_pkg::STATUS_W-1:0]        status_code,
  output logic                                status_report
);
  import lfc_pkg::*;

  cfg_t      cfg;
  state_t    state, state_next;
  ring_ctl_t ring_ctl;

  logic [RANGE_W-1:0]    sens [SENSOR_COUNT];
  logic [FORCE_W-1:0]    force_q;
  logic [SENS_SUM_W-1:0] ssum;
  logic [VCNT_W-1:0]     vcnt;
  logic [VCNT_W-1:0]     scnt;
  logic                  dneg_q;
  logic                  res_write;
  logic [CMD_W-1:0]      res_speed;
  logic [CMD_W-1:0]      res_turn;
  logic                  res_report;
  logic [STATUS_W-1:0]   cur_status;
  logic                  out_load;
  logic                  mode_off;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIV_W-1:0]      div_q;

  logic [WIN_W-1:0]      eff_win;
  logic                  sum_done;
  logic [FSUM_W-1:0]     ring_sum;

  logic [RANGE_W-1:0]    head;
  logic                  head_ok;
  logic [SENS_SUM_W-1:0] head_mm;
  logic [SENS_SUM_W-1:0] ssum_next;
  logic [VCNT_W-1:0]     vcnt_next;

  logic [DIST_W:0]       delta;
  logic [DIST_W:0]       delta_abs;
  logic                  dneg;
  logic [DIST_W-1:0]     dmag;
  logic                  move;

  logic [LIMIT_W-1:0]    spd_mag;
  logic [CMD_W-1:0]      spd_u;
  logic [CMD_W-1:0]      spd_val;

  logic                  fneg;
  logic [FORCE_W:0]      fext;
  logic [FORCE_W:0]      fabs;
  logic [LIMIT_W-1:0]    turn_mag;
  logic [CMD_W-1:0]      turn_u;
  logic [CMD_W-1:0]      turn_val;
  logic [FORCE_W+1:0]    force_lhs;
  logic [FORCE_W+1:0]    force_rhs;
  logic [STATUS_W-1:0]   status_new;

  lfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfc_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  lfc_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .window   (cfg.window),
    .ctl      (ring_ctl),
    .wr_data  (div_q[DIST_W-1:0]),
    .eff_win  (eff_win),
    .sum_done (sum_done),
    .sum      (ring_sum)
  );

  assign mode_off = (cfg.mode == MODE_OFF) || (cfg.mode == MODE_RSVD);

  // Readings are scaled from cm to mm as 8x + 2x.
  assign head      = sens[0];
  assign head_ok   = !head[RANGE_W-1] && (head != '0);
  assign head_mm   = SENS_SUM_W'({head[RANGE_W-2:0], 3'b000}) +
                     SENS_SUM_W'({head[RANGE_W-2:0], 1'b0});
  assign ssum_next = head_ok ? ssum + head_mm : ssum;
  assign vcnt_next = vcnt + VCNT_W'(head_ok);

  assign delta     = {1'b0, div_q[DIST_W-1:0]} - {1'b0, cfg.target};
  assign dneg      = delta[DIST_W];
  assign delta_abs = dneg ? -delta : delta;
  assign dmag      = delta_abs[DIST_W-1:0];
  assign move      = dmag > cfg.dead_zone;

  assign spd_mag = (div_q > DIV_W'(cfg.speed_limit)) ? cfg.speed_limit : div_q[LIMIT_W-1:0];
  assign spd_u   = CMD_W'(spd_mag);
  assign spd_val = dneg_q ? -spd_u : spd_u;

  assign fneg     = force_q[FORCE_W-1];
  assign fext     = {force_q[FORCE_W-1], force_q};
  assign fabs     = fneg ? -fext : fext;
  assign turn_mag = (fabs > (FORCE_W + 1)'(cfg.turn_limit)) ? cfg.turn_limit
                                                            : fabs[LIMIT_W-1:0];
  assign turn_u   = CMD_W'(turn_mag);
  assign turn_val = (fabs > TURN_DEAD) ? (fneg ? -turn_u : turn_u) : '0;

  assign force_lhs  = {fabs, 1'b0};
  assign force_rhs  = (FORCE_W + 2)'({cfg.force_thr, 1'b0}) + (FORCE_W + 2)'(cfg.force_thr);
  assign status_new = (force_lhs > force_rhs) ? ST_FORCE : ST_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    ring_ctl     = '0;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (mode_off || emergency) ? S_FINISH : S_SENS;
        end
      end
      S_SENS: begin
        if (scnt == VCNT_W'(SENSOR_COUNT - 1)) begin
          if (vcnt_next == '0) begin
            state_next = S_FINISH;
          end else begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(ssum_next);
            div_divisor  = DIVISOR_W'(vcnt_next);
            state_next   = S_DIV_AVG;
          end
        end
      end
      S_DIV_AVG: begin
        if (div_done) begin
          ring_ctl.wr_en     = 1'b1;
          ring_ctl.sum_start = 1'b1;
          state_next         = S_WSUM;
        end
      end
      S_WSUM: begin
        if (sum_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(ring_sum);
          div_divisor  = DIVISOR_W'(eff_win);
          state_next   = S_DIV_WIN;
        end
      end
      S_DIV_WIN: begin
        if (div_done) begin
          if (move) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(dmag);
            div_divisor  = SPEED_DIV;
            state_next   = S_DIV_SPD;
          end else begin
            state_next = S_EVAL;
          end
        end
      end
      S_DIV_SPD: begin
        if (div_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          sens[0]    <= range_a_cm;
          sens[1]    <= range_b_cm;
          sens[2]    <= range_c_cm;
          sens[3]    <= range_d_cm;
          force_q    <= leash_force;
          ssum       <= '0;
          vcnt       <= '0;
          scnt       <= '0;
          res_write  <= 1'b1;
          res_speed  <= '0;
          res_turn   <= '0;
          res_report <= 1'b0;
        end
      end
      S_SENS: begin
        for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
          sens[i] <= sens[i+1];
        end
        ssum      <= ssum_next;
        vcnt      <= vcnt_next;
        scnt      <= scnt + 1'b1;
        res_write <= 1'b0;
      end
      S_DIV_WIN: begin
        if (div_done) begin
          dneg_q <= dneg;
        end
      end
      S_DIV_SPD: begin
        if (div_done) begin
          res_speed <= spd_val;
        end
      end
      S_EVAL: begin
        res_turn   <= turn_val;
        res_write  <= cfg.mode == MODE_ACTIVE;
        res_report <= status_new != cur_status;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_status <= ST_OFF;
      out_valid  <= 1'b0;
    end else begin
      if ((state == S_IDLE) && in_valid && mode_off) begin
        cur_status <= ST_OFF;
      end else if (state == S_EVAL) begin
        cur_status <= status_new;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      motor_write   <= res_write;
      speed_cmd     <= res_speed;
      turn_cmd      <= res_turn;
      status_code   <= cur_status;
      status_report <= res_report;
    end
  end

  `LFC_ASSERT_IMP(a_div_done_in_div_state, div_done,
    (state == S_DIV_AVG) || (state == S_DIV_WIN) || (state == S_DIV_SPD))
  `LFC_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state != S_IDLE)
  `LFC_ASSERT_IMP(a_report_not_off, out_valid && status_report, status_code != ST_OFF)

endmodule

/* dv/leash_follow_controller_tb.sv */
// Testbench for leash_follow_controller: drives control ticks and checks every command
// against a cycle-free model of the follow controller kept alongside.
// Depends on lfc_pkg and the RTL of the block; it reads and writes no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lfc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TICK_TOTAL  = 950;

  typedef struct packed {
    logic [SENSOR_COUNT-1:0][RANGE_W-1:0] range_cm;
    logic [FORCE_W-1:0]                   leash_force;
    logic                                 emergency;
  } tick_t;

  typedef struct packed {
    logic               motor_write;
    logic [CMD_W-1:0]   speed;
    logic [CMD_W-1:0]   turn;
    logic [STATUS_W-1:0] status;
    logic               report;
  } cmd_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [RANGE_W-1:0]  range_a_cm = '0;
  logic signed [RANGE_W-1:0]  range_b_cm = '0;
  logic signed [RANGE_W-1:0]  range_c_cm = '0;
  logic signed [RANGE_W-1:0]  range_d_cm = '0;
  logic signed [FORCE_W-1:0]  leash_force = '0;
  logic                       emergency = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       motor_write;
  logic signed [CMD_W-1:0]    speed_cmd;
  logic signed [CMD_W-1:0]    turn_cmd;
  logic [STATUS_W-1:0]        status_code;
  logic                       status_report;

  leash_follow_controller uut (.*);

  always #1 clk = ~clk;

  cfg_t                shadow;
  logic [DIST_W-1:0]   ring_mm [WINDOW_MAX];
  int                  ring_slot;
  logic [STATUS_W-1:0] held_status;

  cmd_t        cmd_expected_q [$];
  int          cmd_mismatches = 0;
  int          ticks_sent = 0;
  int          stall_cycles = 0;
  bit          idle_on = 1'b1;
  bit          valid_up = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned rx_gap;
  cmd_t        want;
  cmd_t        got;

  function automatic int clamp_sym(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(10) : 0;
  endfunction

  function automatic cmd_t follow_predict(tick_t t);
    cmd_t r;
    int   sum_mm, hits, rd, win, fsum, user_mm, delta, spd, trn, force_v, absf;
    logic [STATUS_W-1:0] st;
    r = '0;
    spd = 0;
    trn = 0;
    if (shadow.mode == MODE_OFF || shadow.mode == MODE_RSVD) begin
      held_status = ST_OFF;
      r.motor_write = 1'b1;
    end else if (t.emergency) begin
      r.motor_write = 1'b1;
    end else begin
      sum_mm = 0;
      hits = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        rd = $signed(t.range_cm[i]);
        if (rd > 0) begin
          sum_mm += rd * 10;
          hits++;
        end
      end
      if (hits > 0) begin
        win = (shadow.window < 1) ? 1 :
              (shadow.window > WINDOW_MAX) ? WINDOW_MAX : int'(shadow.window);
        ring_mm[ring_slot % WINDOW_MAX] = DIST_W'(sum_mm / hits);
        ring_slot++;
        if (ring_slot >= win) ring_slot = 0;
        fsum = 0;
        for (int i = 0; i < win; i++) fsum += ring_mm[i];
        user_mm = fsum / win;
        delta = user_mm - int'(shadow.target);
        if ((delta < 0 ? -delta : delta) > int'(shadow.dead_zone))
          spd = clamp_sym(delta / 10, int'(shadow.speed_limit));
        force_v = $signed(t.leash_force);
        absf = force_v < 0 ? -force_v : force_v;
        if (absf > 5) trn = clamp_sym(force_v, int'(shadow.turn_limit));
        r.motor_write = (shadow.mode == MODE_ACTIVE);
        st = (2 * absf > 3 * int'(shadow.force_thr)) ? ST_FORCE : ST_OK;
        if (st != held_status) begin
          held_status = st;
          r.report = 1'b1;
        end
      end
    end
    r.speed = CMD_W'(spd);
    r.turn = CMD_W'(trn);
    r.status = held_status;
    return r;
  endfunction

  function automatic tick_t mk_tick(int a, int b, int c, int d, int f, bit e);
    tick_t t;
    t.range_cm[0] = RANGE_W'(a);
    t.range_cm[1] = RANGE_W'(b);
    t.range_cm[2] = RANGE_W'(c);
    t.range_cm[3] = RANGE_W'(d);
    t.leash_force = FORCE_W'(f);
    t.emergency = e;
    return t;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int    center, lvl, thr_edge;
    center = int'(shadow.target) / 10;
    if (center < 1) center = 1;
    if (center > 1000) center = 1000;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      case ($urandom_range(19))
        0: t.range_cm[i] = $urandom_range(1) ? '1 : '0;
        1: t.range_cm[i] = RANGE_W'($urandom);
        2, 3, 4: t.range_cm[i] = RANGE_W'($urandom_range(1000, 1));
        default: begin
          lvl = center + int'($urandom_range(60)) - 30;
          if (lvl < 1) lvl = 1;
          if (lvl > 1000) lvl = 1000;
          t.range_cm[i] = RANGE_W'(lvl);
        end
      endcase
    end
    if ($urandom_range(29) == 0) t.range_cm = '1;
    thr_edge = (3 * int'(shadow.force_thr)) / 2 + int'($urandom_range(4)) - 2;
    if (thr_edge > 32767) thr_edge = 32767;
    case ($urandom_range(5))
      0: lvl = int'($urandom_range(16)) - 8;
      1: lvl = thr_edge;
      2: lvl = -thr_edge;
      3: lvl = int'($urandom_range(65535)) - 32768;
      default: lvl = int'($urandom_range(1000)) - 500;
    endcase
    t.leash_force = FORCE_W'(lvl);
    t.emergency = ($urandom_range(11) == 0);
    return t;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    case ($urandom_range(11))
      0: c.mode = MODE_OFF;
      1: c.mode = MODE_RSVD;
      2, 3, 4, 5: c.mode = MODE_TEST;
      default: c.mode = MODE_ACTIVE;
    endcase
    case ($urandom_range(9))
      0: c.target = '0;
      1: c.target = '1;
      2: c.target = DIST_W'($urandom);
      default: c.target = DIST_W'($urandom_range(4000, 300));
    endcase
    c.speed_limit = ($urandom_range(3) == 0) ? LIMIT_W'($urandom) : LIMIT_W'($urandom_range(300));
    c.turn_limit = ($urandom_range(3) == 0) ? LIMIT_W'($urandom) : LIMIT_W'($urandom_range(300));
    c.window = WIN_W'($urandom);
    c.dead_zone = ($urandom_range(3) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(200));
    c.force_thr = ($urandom_range(3) == 0) ? LIMIT_W'($urandom) : LIMIT_W'($urandom_range(400));
    return c;
  endfunction

  task automatic note_mismatch(string why, cmd_t exp_cmd, cmd_t act_cmd);
    cmd_mismatches++;
    if (cmd_mismatches <= 10)
      $display("%s: expected write=%0b speed=%0d turn=%0d status=%0d report=%0b, got write=%0b speed=%0d turn=%0d status=%0d report=%0b",
               why, exp_cmd.motor_write, $signed(exp_cmd.speed), $signed(exp_cmd.turn),
               exp_cmd.status, exp_cmd.report, act_cmd.motor_write, $signed(act_cmd.speed),
               $signed(act_cmd.turn), act_cmd.status, act_cmd.report);
  endtask

  task automatic send_tick(tick_t t);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      if (valid_up) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    valid_up = 1'b1;
    range_a_cm <= t.range_cm[0];
    range_b_cm <= t.range_cm[1];
    range_c_cm <= t.range_cm[2];
    range_d_cm <= t.range_cm[3];
    leash_force <= t.leash_force;
    emergency <= t.emergency;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cmd_expected_q.push_back(follow_predict(t));
    ticks_sent++;
  endtask

  task automatic settle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (cmd_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:      shadow.mode = value[MODE_W-1:0];
      REG_TARGET:    shadow.target = value[DIST_W-1:0];
      REG_SPEED_LIM: shadow.speed_limit = value[LIMIT_W-1:0];
      REG_TURN_LIM:  shadow.turn_limit = value[LIMIT_W-1:0];
      REG_WINDOW:    shadow.window = value[WIN_W-1:0];
      REG_DEAD_ZONE: shadow.dead_zone = value[DIST_W-1:0];
      REG_FORCE_THR: shadow.force_thr = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(cfg_t c);
    settle();
    write_reg(REG_MODE, PDATA_W'(c.mode));
    write_reg(REG_TARGET, PDATA_W'(c.target));
    write_reg(REG_SPEED_LIM, PDATA_W'(c.speed_limit));
    write_reg(REG_TURN_LIM, PDATA_W'(c.turn_limit));
    write_reg(REG_WINDOW, PDATA_W'(c.window));
    write_reg(REG_DEAD_ZONE, PDATA_W'(c.dead_zone));
    write_reg(REG_FORCE_THR, PDATA_W'(c.force_thr));
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_tick(rand_tick());
  endtask

  task automatic test_mode_off();
    send_tick(mk_tick(100, 100, 100, 100, 300, 1'b0));
    send_tick(mk_tick(100, 100, 100, 100, 300, 1'b1));
    settle();
    write_reg(REG_MODE, PDATA_W'(MODE_RSVD));
    send_tick(mk_tick(120, 80, 100, 100, -300, 1'b0));
  endtask

  task automatic test_active_paths();
    settle();
    write_reg(REG_MODE, PDATA_W'(MODE_ACTIVE));
    send_tick(mk_tick(100, 100, 100, 100, 0, 1'b0));
    send_tick(mk_tick(1000, 1000, 1000, 1000, 32767, 1'b0));
    send_tick(mk_tick(-1, -1, -1, -1, 200, 1'b0));
    send_tick(mk_tick(0, 0, 0, 0, -200, 1'b0));
    send_tick(mk_tick(1023, -1024, 0, -1, -32768, 1'b0));
    send_tick(mk_tick(1, -1, -1, -1, 5, 1'b0));
    send_tick(mk_tick(150, 150, 150, 150, -5, 1'b0));
    send_tick(mk_tick(150, 150, 150, 150, 6, 1'b0));
    send_tick(mk_tick(150, 150, 150, 150, -6, 1'b0));
    send_tick(mk_tick(100, 100, 100, 100, 150, 1'b0));
    send_tick(mk_tick(100, 100, 100, 100, 151, 1'b0));
    send_tick(mk_tick(100, 100, 100, 100, 151, 1'b1));
    send_tick(mk_tick(50, 50, 50, 50, -151, 1'b0));
  endtask

  task automatic test_test_mode();
    settle();
    write_reg(REG_MODE, PDATA_W'(MODE_TEST));
    send_tick(mk_tick(300, 300, 300, 300, 120, 1'b0));
    send_tick(mk_tick(20, 20, -1, 20, 1000, 1'b0));
    send_tick(mk_tick(20, 20, 20, 20, 1000, 1'b1));
  endtask

  task automatic test_config_extremes();
    apply_cfg('{mode: MODE_ACTIVE, target: '0, speed_limit: '0, turn_limit: '0,
                window: '0, dead_zone: '0, force_thr: '0});
    run_ticks(20);
    idle_on = 1'b0;
    apply_cfg('{mode: MODE_TEST, target: '1, speed_limit: '1, turn_limit: '1,
                window: '1, dead_zone: '1, force_thr: '1});
    run_ticks(20);
    idle_on = 1'b1;
    apply_cfg('{mode: MODE_ACTIVE, target: 10000, speed_limit: '1, turn_limit: '1,
                window: 1, dead_zone: '0, force_thr: '1});
    run_ticks(20);
    apply_cfg('{mode: MODE_ACTIVE, target: 1000, speed_limit: 100, turn_limit: 100,
                window: 10, dead_zone: 50, force_thr: 100});
    run_ticks(20);
    apply_cfg('{mode: MODE_ACTIVE, target: 2500, speed_limit: 100, turn_limit: 100,
                window: 3, dead_zone: 50, force_thr: 100});
    run_ticks(20);
  endtask

  task automatic test_random_ticks();
    while (ticks_sent < TICK_TOTAL) begin
      apply_cfg(rand_cfg());
      idle_on = ($urandom_range(3) != 0);
      run_ticks($urandom_range(90, 40));
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        rx_gap = draw_gap();
        if (rx_gap != 0) begin
          out_ready <= 1'b0;
          ready_hold <= rx_gap - 1;
        end
      end
    end else if (ready_hold == 0) begin
      out_ready <= 1'b1;
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got.motor_write = motor_write;
      got.speed = speed_cmd;
      got.turn = turn_cmd;
      got.status = status_code;
      got.report = status_report;
      if (cmd_expected_q.size() == 0) begin
        note_mismatch("command with no tick pending", '0, got);
      end else begin
        want = cmd_expected_q.pop_front();
        if (got.motor_write !== want.motor_write || got.speed !== want.speed ||
            got.turn !== want.turn || got.status !== want.status ||
            got.report !== want.report)
          note_mismatch("command mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    shadow = '{mode: MODE_OFF, target: 1000, speed_limit: 100, turn_limit: 100,
               window: 10, dead_zone: 50, force_thr: 100};
    foreach (ring_mm[i]) ring_mm[i] = RING_RESET;
    ring_slot = 0;
    held_status = ST_OFF;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_mode_off();
    test_active_paths();
    test_test_mode();
    test_config_extremes();
    test_random_ticks();
    settle();
    repeat (100) @(posedge clk);
    if (cmd_mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lfc_pkg.sv
rtl/core/lfc_regs.sv
rtl/core/lfc_serdiv.sv
rtl/core/lfc_ring.sv
rtl/core/leash_follow_controller.sv
dv/leash_follow_controller_tb.sv
